>>> rtl/fdls_pkg.sv
// ----------------------------------------------------------------------------
// fdls_pkg
// Types and constants shared by the slewed feedback delay line and its checker.
// ----------------------------------------------------------------------------
package fdls_pkg;

  // Field and register widths fixed by the block's interface.
  localparam int TARGET_W   = 18;  // target delay, whole samples
  localparam int GAIN_W     = 16;  // feedback gain, unsigned Q1.15
  localparam int GAIN_FRAC  = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;  // widest register

  // Read offset: unsigned, 16 fraction bits.
  localparam int FRAC_W   = 16;
  localparam int OFFSET_W = TARGET_W + FRAC_W;
  localparam int WHOLE_W  = TARGET_W;

  // Slew step, same scale as the offset.
  localparam int STEP_W = 18;
  localparam logic [STEP_W-1:0] STEP_MIN = 18'd32768;   // 0.5 sample
  localparam logic [STEP_W-1:0] STEP_MAX = 18'd196608;  // 3.0 samples

  // Step is distance / 2000: below MAG_STEP_LO it clamps to STEP_MIN,
  // from MAG_STEP_HI upwards to STEP_MAX.
  localparam logic [OFFSET_W-1:0] MAG_STEP_LO = 34'd65536000;
  localparam logic [OFFSET_W-1:0] MAG_STEP_HI = 34'd393218000;

  // distance / 2000 = (distance >> 4) / 125, the latter by reciprocal
  // multiplication; exact for a quotient input below 2^25.
  localparam int MAG_SHR     = 4;
  localparam int QUOT_IN_W   = 25;
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP_125 = 26'd34359739;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

endpackage

>>> rtl/feedback_delay_line_slewed_core.sv
// ----------------------------------------------------------------------------
// feedback_delay_line_slewed_core
// Mono feedback delay line on one ring memory with a slewed read offset.
// ----------------------------------------------------------------------------
// Each input transaction passes through two states in the core: a read
// cycle that clears the slot one ahead of the write pointer and reads the
// slot at the read pointer, then a write cycle that stores input plus gain
// times the read sample (saturated) at the write pointer and hands the read
// sample to the output register. A new transaction is taken as the write
// cycle of the previous one completes, so at most one transaction is in the
// core at a time, a limit set by the single write port of the ring memory
// (clear, then store). A waiting output holds the write cycle until the
// output register is taken, and the input stays stalled for that time.
// During a configuration write, and while the hold flag registered from it
// is set, the input is stalled while the slew distance is recomputed. There
// is no clearing pass after reset: until the write pointer first wraps, any
// slot at or beyond it reads as zero. STORE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module feedback_delay_line_slewed_core #(
  parameter int STORE_DEPTH = 262144,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [fdls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdls_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input samples
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  // delayed samples
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_delayed_out
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int SB = SAMPLE_BITS;
  localparam int OW = fdls_pkg::OFFSET_W;

  // Saturation limits at the width of the feedback sum.
  localparam logic signed [SB+2:0] SUM_HI = {4'b0000, {(SB-1){1'b1}}};
  localparam logic signed [SB+2:0] SUM_LO = {4'b1111, {(SB-1){1'b0}}};

  // Ring memory
  logic [SB-1:0] mem [STORE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SB-1:0] mem_wdata;
  logic          rd_en;
  logic [SB-1:0] rd_q_r;

  // Control state
  fdls_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    wp_r, rp_r, rp_nxt;
  logic             wrapped_r;
  logic [OW-1:0]    offset_r, offset_nxt;
  logic [fdls_pkg::TARGET_W-1:0] target_r;
  logic [fdls_pkg::GAIN_W-1:0]   gain_r;
  logic             cfg_hold_r;
  logic             out_valid_r;

  // Payload
  logic signed [SB-1:0] sample_r;
  logic                 zero_r, zero_nxt;
  logic signed [SB-1:0] out_data_r;

  logic in_accept;
  logic out_free;
  logic wr_done;

  // --------------------------------------------------------------------------
  // Slew, stage one: distance to the target, every cycle.
  // --------------------------------------------------------------------------
  logic [OW-1:0] tgt_fix;
  logic [OW-1:0] mag_r, mag_nxt;
  logic          neg_r, neg_nxt;

  assign tgt_fix = {target_r, {fdls_pkg::FRAC_W{1'b0}}};

  always_comb begin
    neg_nxt = offset_r > tgt_fix;
    mag_nxt = neg_nxt ? (offset_r - tgt_fix) : (tgt_fix - offset_r);
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
  end

  // --------------------------------------------------------------------------
  // Slew, stage two: step and new offset, committed in the read cycle.
  // --------------------------------------------------------------------------
  logic [fdls_pkg::QUOT_IN_W-1:0]                  quot_in;
  logic [fdls_pkg::QUOT_IN_W+fdls_pkg::RECIP_W-1:0] quot_prod;
  logic [fdls_pkg::STEP_W-1:0]                     quot;
  logic [fdls_pkg::STEP_W-1:0]                     step;
  logic                                            snap;

  always_comb begin
    quot_in   = mag_r[fdls_pkg::MAG_SHR +: fdls_pkg::QUOT_IN_W];
    quot_prod = quot_in * fdls_pkg::RECIP_125;
    quot      = quot_prod[fdls_pkg::RECIP_SHIFT +: fdls_pkg::STEP_W];
    // under one sample away: land on the target
    snap      = (mag_r[OW-1:fdls_pkg::FRAC_W] == '0);
    if (mag_r < fdls_pkg::MAG_STEP_LO) begin
      step = fdls_pkg::STEP_MIN;
    end else if (mag_r >= fdls_pkg::MAG_STEP_HI) begin
      step = fdls_pkg::STEP_MAX;
    end else begin
      step = quot;
    end
    if (snap) begin
      offset_nxt = tgt_fix;
    end else if (neg_r) begin
      offset_nxt = offset_r - OW'(step);
    end else begin
      offset_nxt = offset_r + OW'(step);
    end
  end

  // --------------------------------------------------------------------------
  // Read pointer for the next transaction: write pointer + 1 minus the
  // offset rounded up, taken in the write cycle after the offset commit.
  // --------------------------------------------------------------------------
  logic [fdls_pkg::WHOLE_W-1:0] whole;

  always_comb begin
    whole  = offset_r[OW-1:fdls_pkg::FRAC_W]
           + fdls_pkg::WHOLE_W'(|offset_r[fdls_pkg::FRAC_W-1:0]);
    rp_nxt = wp_r + AW'(1) - AW'(whole);
  end

  // Slot reads as zero if it is the one being cleared, or has not been
  // written since reset.
  assign zero_nxt = (rp_r == wp_r + AW'(1)) || (!wrapped_r && (rp_r >= wp_r));

  // --------------------------------------------------------------------------
  // Feedback sum
  // --------------------------------------------------------------------------
  logic signed [SB-1:0]  rd_val;
  logic signed [SB+16:0] fb_prod;
  logic signed [SB+1:0]  fb_val;
  logic signed [SB+2:0]  fb_sum;
  logic signed [SB-1:0]  fb_sat;

  always_comb begin
    rd_val  = zero_r ? '0 : $signed(rd_q_r);
    fb_prod = rd_val * $signed({1'b0, gain_r});
    fb_val  = fb_prod[SB+16:fdls_pkg::GAIN_FRAC];   // floor of product >> 15
    fb_sum  = (SB+3)'(sample_r) + (SB+3)'(fb_val);
    if (fb_sum > SUM_HI) begin
      fb_sat = {1'b0, {(SB-1){1'b1}}};
    end else if (fb_sum < SUM_LO) begin
      fb_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      fb_sat = fb_sum[SB-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign out_free  = !out_valid_r || !out_stall;
  assign wr_done   = (state_r == fdls_pkg::ST_WRITE) && out_free;
  assign in_accept = in_valid && !in_stall;

  // Next state
  always_comb begin
    case (state_r)
      fdls_pkg::ST_IDLE:  state_nxt = in_accept ? fdls_pkg::ST_READ : fdls_pkg::ST_IDLE;
      fdls_pkg::ST_READ:  state_nxt = fdls_pkg::ST_WRITE;
      fdls_pkg::ST_WRITE: begin
        if (!out_free) begin
          state_nxt = fdls_pkg::ST_WRITE;
        end else begin
          state_nxt = in_accept ? fdls_pkg::ST_READ : fdls_pkg::ST_IDLE;
        end
      end
      default:            state_nxt = fdls_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall  = !rst_n || cfg_wr_en || cfg_hold_r;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wp_r;
    mem_wdata = fb_sat;
    case (state_r)
      fdls_pkg::ST_IDLE: ;
      fdls_pkg::ST_READ: begin
        in_stall  = 1'b1;
        rd_en     = 1'b1;
        mem_we    = 1'b1;          // clear the slot one ahead
        mem_waddr = wp_r + AW'(1);
        mem_wdata = '0;
      end
      fdls_pkg::ST_WRITE: begin
        in_stall  = in_stall || !out_free;
        mem_we    = out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // --------------------------------------------------------------------------
  // Ring memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q_r <= mem[rp_r];
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fdls_pkg::ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      wrapped_r   <= 1'b0;
      offset_r    <= '0;
      target_r    <= '0;
      gain_r      <= '0;
      cfg_hold_r  <= 1'b1;       // lets the slew distance settle after reset
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cfg_hold_r <= cfg_wr_en;
      if (cfg_wr_en) begin
        case (cfg_index)
          fdls_pkg::REG_TARGET_DELAY:  target_r <= cfg_wdata[fdls_pkg::TARGET_W-1:0];
          fdls_pkg::REG_FEEDBACK_GAIN: gain_r   <= cfg_wdata[fdls_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (state_r == fdls_pkg::ST_READ) begin
        offset_r <= offset_nxt;
      end
      if (state_r == fdls_pkg::ST_WRITE) begin
        rp_r <= rp_nxt;
      end
      if (wr_done) begin
        wp_r <= wp_r + AW'(1);
        if (wp_r == '1) begin
          wrapped_r <= 1'b1;
        end
      end
      if (wr_done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= in_sample_in;
    end
    if (state_r == fdls_pkg::ST_READ) begin
      zero_r <= zero_nxt;
    end
    if (wr_done) begin
      out_data_r <= rd_val;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_delayed_out = out_data_r;

endmodule

>>> rtl/fdls_checker.sv
// ----------------------------------------------------------------------------
// fdls_checker
// Port-level checks on the slewed feedback delay line, bound to its top level.
// ----------------------------------------------------------------------------
module fdls_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_delayed_out
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // Only one transaction in the core: the cycle after an accept is stalled.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken during read cycle");

  // A fresh result traces back to an accepted transaction, through the read and write states.
  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
    else $error("result without matching transaction");

  // Result data holds while stalled.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_delayed_out))
    else $error("stalled result changed");

endmodule

bind feedback_delay_line_slewed_core fdls_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_fdls_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_delayed_out(out_delayed_out)
);

>>> tb/delay_line_checker.sv
// ----------------------------------------------------------------------------
// delay_line_checker
// Watches the configuration port and both sample channels of the slewed
// feedback delay line. It keeps its own ring store, pointers, read offset
// and registers, predicts each delayed sample and compares it with the
// block's output transactions.
// ----------------------------------------------------------------------------
module delay_line_checker #(
  parameter int STORE_DEPTH = 262144,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [fdls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdls_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [SAMPLE_BITS-1:0]       out_delayed_out,
  output int                                  pending_echoes,
  output int                                  echo_failures
);
  import fdls_pkg::*;

  localparam int     ADDR_W     = $clog2(STORE_DEPTH);
  localparam longint ONE_SAMPLE = longint'(1) << FRAC_W;
  localparam longint SLEW_MIN   = 32768;
  localparam longint SLEW_MAX   = 196608;
  localparam longint SLEW_DIV   = 2000;
  localparam longint SAMPLE_HI  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO  = -SAMPLE_HI - 1;

  bit signed [SAMPLE_BITS-1:0] ring [STORE_DEPTH];
  bit [ADDR_W-1:0]             wr_ptr;
  bit [ADDR_W-1:0]             rd_ptr;
  longint                      offset_fix;   // 16 fraction bits
  bit [TARGET_W-1:0]           target_delay;
  bit [GAIN_W-1:0]             feedback_gain;
  int                          mismatch_count;
  logic signed [SAMPLE_BITS-1:0] expected_echo [$];
  logic signed [SAMPLE_BITS-1:0] want;

  // One input transaction: clear ahead, tap, write back with feedback,
  // then slew the offset and move both pointers.
  task automatic predict_echo(input logic signed [SAMPLE_BITS-1:0] smp);
    bit [ADDR_W-1:0]             clr_slot;
    bit signed [SAMPLE_BITS-1:0] tap;
    longint                      mix;
    longint                      tgt_fix;
    longint                      gap;
    longint                      mag;
    longint                      step;
    longint                      whole;
    clr_slot = wr_ptr + 1'b1;
    ring[clr_slot] = '0;
    tap = ring[rd_ptr];
    // >>> on a signed product floors toward minus infinity
    mix = longint'(smp) + ((longint'(tap) * longint'(feedback_gain)) >>> GAIN_FRAC);
    if (mix > SAMPLE_HI) mix = SAMPLE_HI;
    if (mix < SAMPLE_LO) mix = SAMPLE_LO;
    ring[wr_ptr] = mix[SAMPLE_BITS-1:0];
    expected_echo.push_back(tap);

    tgt_fix = longint'(target_delay) << FRAC_W;
    if (offset_fix != tgt_fix) begin
      gap = tgt_fix - offset_fix;
      mag = (gap < 0) ? -gap : gap;
      if (mag < ONE_SAMPLE) begin
        offset_fix = tgt_fix;
      end else begin
        step = mag / SLEW_DIV;
        if (step > SLEW_MAX) step = SLEW_MAX;
        if (step < SLEW_MIN) step = SLEW_MIN;
        offset_fix = (gap < 0) ? offset_fix - step : offset_fix + step;
      end
    end
    wr_ptr = wr_ptr + 1'b1;
    whole  = (offset_fix + ONE_SAMPLE - 1) >>> FRAC_W;
    rd_ptr = wr_ptr - whole[ADDR_W-1:0];
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (ring[i]) ring[i] = '0;
      wr_ptr         = '0;
      rd_ptr         = '0;
      offset_fix     = 0;
      target_delay   = '0;
      feedback_gain  = '0;
      mismatch_count = 0;
      expected_echo.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TARGET_DELAY:  target_delay  = cfg_wdata[TARGET_W-1:0];
          REG_FEEDBACK_GAIN: feedback_gain = cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      // results first: a result never belongs to the sample taken this edge
      if (out_valid && !out_stall) begin
        if (expected_echo.size() == 0) begin
          $error("delayed_out: expected none, actual %0d", out_delayed_out);
          mismatch_count++;
        end else begin
          want = expected_echo.pop_front();
          if (out_delayed_out !== want) begin
            $error("delayed_out: expected %0d, actual %0d", want, out_delayed_out);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_echo(in_sample_in);
    end
    pending_echoes <= expected_echo.size();
    echo_failures  <= mismatch_count;
  end

endmodule

>>> tb/feedback_delay_line_slewed_core_test.sv
// ----------------------------------------------------------------------------
// feedback_delay_line_slewed_core_test
// Stimulus and verdict for the slewed feedback delay line. Directed samples
// and register settings come first, then randomised phases, most with bursty
// idling on both channels, then a short unthrottled soak with the largest
// slew steps up towards the full store length and back down.
// ----------------------------------------------------------------------------
module feedback_delay_line_slewed_core_test;
  import fdls_pkg::*;

  localparam int STORE_DEPTH    = 262144;
  localparam int SAMPLE_BITS    = 24;
  localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transaction at all

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // indexes with no register behind them; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // gain codes of interest: unity, 1.5 and full scale
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd32768;
  localparam logic [GAIN_W-1:0] GAIN_FULL  = 16'hFFFF;
  localparam logic [GAIN_W-1:0] GAIN_1P5   = 16'd49152;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample_in;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] out_delayed_out;

  int pending_echoes;
  int echo_failures;
  int tx_gap_pct;      // chance per transaction of a sender gap
  int rx_stall_pct;    // chance per cycle of a receiver stall burst
  int quiet_cycles = 0;

  feedback_delay_line_slewed_core #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_delayed_out (out_delayed_out)
  );

  delay_line_checker #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) echo_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_delayed_out (out_delayed_out),
    .pending_echoes  (pending_echoes),
    .echo_failures   (echo_failures)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog: any transaction on either sample channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall bursts, rate set per phase.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(1, 100) <= rx_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Full-range noise half the time, otherwise one of the rails, zero or -1.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // One input transaction, optionally preceded by an idle gap. Returns at
  // the edge where it is taken; the payload holds while stalled.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp);
    if ($urandom_range(1, 100) <= tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender until every predicted sample has come out. The first
  // edge lets the checker's count catch up with the last transaction.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_echoes != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers and one unmapped index, only with the block idle.
  // The gain word carries random bits above the register.
  task automatic program_regs(input logic [TARGET_W-1:0] tgt, input logic [GAIN_W-1:0] gain);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_TARGET_DELAY;
    cfg_wdata <= tgt;
    @(posedge clk);
    cfg_index <= REG_FEEDBACK_GAIN;
    cfg_wdata <= {2'($urandom_range(0, 3)), gain};
    @(posedge clk);
    cfg_index <= ($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [TARGET_W-1:0] tgt;
    logic [GAIN_W-1:0]   gain;

    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= REG_TARGET_DELAY;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_sample_in <= '0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---------------------------------------------------------
    // reset registers: zero delay, no feedback; the tap sees the slot
    // before this sample's write
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample('1);
    send_sample(SAMPLE_BITS'(1));

    // one-sample delay with gain just under 2: feedback saturates both rails
    program_regs(TARGET_W'(1), GAIN_FULL);
    repeat (4) send_sample(SAMPLE_MAX);
    repeat (4) send_sample(SAMPLE_MIN);

    // back to zero delay at unity: offset steps down from one sample, then snaps
    program_regs(TARGET_W'(0), GAIN_UNITY);
    send_sample(SAMPLE_BITS'(1));
    send_sample('1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);

    // full-scale target starts the largest slew steps
    program_regs('1, 16'd1);
    repeat (4) send_sample(pick_sample());

    // --- random phases with idling -----------------------------------------
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 9))
        7, 8:    tgt = TARGET_W'($urandom_range(0, 4000));
        9:       tgt = TARGET_W'($urandom);
        default: tgt = TARGET_W'($urandom_range(0, 64));
      endcase
      case ($urandom_range(0, 3))
        0:       gain = '0;
        1:       gain = GAIN_UNITY;
        2:       gain = GAIN_FULL;
        default: gain = GAIN_W'($urandom);
      endcase
      program_regs(tgt, gain);
      case ($urandom_range(0, 2))
        0: begin
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_gap_pct   = 10;
          rx_stall_pct = 3;
        end
        default: begin
          tx_gap_pct   = 40;
          rx_stall_pct = 10;
        end
      endcase
      for (int k = 0; k < 84; k++) begin
        // now and then the sender waits for the pipeline to empty mid-phase
        if (k == 42 && (ph % 4) == 1) drain_results();
        send_sample(pick_sample());
      end
    end

    // --- soak, no idling ---------------------------------------------------
    // Slew up towards the full store length at the largest steps, then
    // back down to a short delay through older data.
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    program_regs('1, GAIN_1P5);
    repeat (70) send_sample(pick_sample());
    program_regs(TARGET_W'($urandom_range(0, 31)), GAIN_W'($urandom));
    repeat (70) send_sample(pick_sample());

    drain_results();
    repeat (16) @(posedge clk);
    if (echo_failures == 0 && pending_echoes == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
